/* src/token_span_table_with_splice_defines.svh */
// Assertion macros for the checker file of the token span table.
// Every property is sampled on the rising edge of clock and is switched off
// while reset is high.
`ifndef TOKEN_SPAN_TABLE_WITH_SPLICE_DEFINES_SVH
`define TOKEN_SPAN_TABLE_WITH_SPLICE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TSPAN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TSPAN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/tspan_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tspan_pkg;

   // Table size and payload width.
   localparam int CAPACITY     = 64;
   localparam int PAYLOAD_BITS = 32;

   // Fixed widths of the word fields.
   localparam int OP_W    = 3;
   localparam int FIELD_W = 7;
   localparam int END_W   = 32;
   localparam int DATA_W  = 32;
   localparam int ST_W    = 2;

   // Derived widths: entry index, entry count and a working width that holds
   // the sum of two counts without overflow.
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CW      = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;
   localparam int ENTRY_W = END_W + PAYLOAD_BITS;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_READ   = 3'd1,
      OP_SPLICE = 3'd2,
      OP_FILL   = 3'd3,
      OP_SEARCH = 3'd4
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_BOUNDS   = 2'd1,
      ST_CAPACITY = 2'd2,
      ST_NO_GAP   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_READ_WAIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_ZERO,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

/* src/tspan_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tspan_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/token_span_table_with_splice.sv */
`timescale 1ns / 1ps
`default_nettype none

// Ordered token table with splice and lower-bound search. Each entry holds a
// 32-bit end byte offset and a payload in a single-port-write, registered-read
// RAM driven by a small sequencer, and the block takes one word at a time:
// req_stall is high from the cycle after a word is accepted until its result
// has been moved into the output register, so a result may wait on rsp_stall
// while the next word is already being worked on. Push, fill, rejected
// operations and unused opcodes go from decode straight to the finish state;
// read waits for the RAM read data first; search repeats a probe, which is
// one RAM read followed by one compare, until its range is empty; and splice
// moves the tail, the entries behind the removed run, when the insert and
// remove counts differ, with one read and one write through the RAM for every
// moved entry, then clears the gap. A result still held by rsp_stall keeps
// the sequencer in its finish state. A splice zeroes the new gap and leaves
// it open for fill words; an accepted push or another accepted splice closes
// a gap that is still open.
module token_span_table_with_splice (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [tspan_pkg::OP_W-1:0]     req_opcode,
   input  wire logic [tspan_pkg::FIELD_W-1:0]  req_position,
   input  wire logic [tspan_pkg::FIELD_W-1:0]  req_remove_count,
   input  wire logic [tspan_pkg::FIELD_W-1:0]  req_insert_count,
   input  wire logic [tspan_pkg::END_W-1:0]    req_end_byte_in,
   input  wire logic [tspan_pkg::DATA_W-1:0]   req_payload_in,
   input  wire logic [tspan_pkg::END_W-1:0]    req_byte_offset,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [tspan_pkg::ST_W-1:0]     rsp_status,
   output logic      [tspan_pkg::FIELD_W-1:0]  rsp_found_index,
   output logic      [tspan_pkg::END_W-1:0]    rsp_end_byte_out,
   output logic      [tspan_pkg::DATA_W-1:0]   rsp_payload_out,
   output logic      [tspan_pkg::FIELD_W-1:0]  rsp_entry_count
);

   import tspan_pkg::*;

   state_type               state_ff, state_in;

   // Latched request word.
   op_type                  op_ff, op_in;
   logic [FIELD_W-1:0]      pos_ff, pos_in;
   logic [FIELD_W-1:0]      rem_ff, rem_in;
   logic [FIELD_W-1:0]      ins_ff, ins_in;
   logic [END_W-1:0]        eb_ff, eb_in;
   logic [PAYLOAD_BITS-1:0] pl_ff, pl_in;
   logic [END_W-1:0]        key_ff, key_in;

   // Table bookkeeping.
   logic [CNT_W-1:0]        used_ff, used_in;
   logic [CNT_W-1:0]        fptr_ff, fptr_in;
   logic [CNT_W-1:0]        frem_ff, frem_in;

   // Sequencer pointers for the tail move, gap clear and search.
   logic [IDX_W-1:0]        src_ff, src_in;
   logic [IDX_W-1:0]        dst_ff, dst_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    up_ff, up_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        mid_ff, mid_in;

   // Result being built.
   status_type              wk_status_ff, wk_status_in;
   logic [FIELD_W-1:0]      wk_found_ff, wk_found_in;
   logic [END_W-1:0]        wk_eb_ff, wk_eb_in;
   logic [PAYLOAD_BITS-1:0] wk_pl_ff, wk_pl_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff;
   logic [FIELD_W-1:0]      rsp_found_ff;
   logic [END_W-1:0]        rsp_eb_ff;
   logic [PAYLOAD_BITS-1:0] rsp_pl_ff;
   logic [FIELD_W-1:0]      rsp_count_ff;

   // RAM port signals.
   logic                    mem_wr_en;
   logic [IDX_W-1:0]        mem_wr_addr;
   logic [ENTRY_W-1:0]      mem_wr_data;
   logic                    mem_rd_en;
   logic [IDX_W-1:0]        mem_rd_addr;
   logic [ENTRY_W-1:0]      mem_rd_data;

   // Shared arithmetic on the working width.
   logic [CW-1:0]           pos_w, rem_w, ins_w, used_w, lo_w;
   logic [CW-1:0]           span_w, needed_w, tail_w, mid_w, fptr_w;
   logic [CW-1:0]           src_up_w, dst_up_w, dst_dn_w;
   logic                    req_take, out_free, load_out;
   logic                    read_bad, splice_bad, splice_big, shift_needed;
   logic                    push_full, fill_none, probe_le, search_more;

   tspan_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Handshake terms.
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == S_FINISH) && out_free;

   // Bounds, sizes and pointers, all on one widened add/compare path.
   always_comb begin
      pos_w        = CW'(pos_ff);
      rem_w        = CW'(rem_ff);
      ins_w        = CW'(ins_ff);
      used_w       = CW'(used_ff);
      lo_w         = CW'(lo_ff);
      fptr_w       = CW'(fptr_ff);
      span_w       = pos_w + rem_w;
      needed_w     = used_w - rem_w + ins_w;
      tail_w       = used_w - span_w;
      mid_w        = (lo_w + CW'(hi_ff)) >> 1;
      src_up_w     = used_w - CW'(1);
      dst_up_w     = needed_w - CW'(1);
      dst_dn_w     = pos_w + ins_w;
      read_bad     = (pos_w >= used_w);
      splice_bad   = (pos_w > used_w) || (span_w > used_w);
      splice_big   = (needed_w > CW'(CAPACITY));
      shift_needed = (ins_w != rem_w) && (tail_w != '0);
      push_full    = (used_w >= CW'(CAPACITY));
      fill_none    = (frem_ff == '0) || (fptr_w >= CW'(CAPACITY));
      probe_le     = (mem_rd_data[ENTRY_W-1 -: END_W] <= key_ff);
      search_more  = (lo_ff < hi_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (op_ff)
               OP_READ: begin
                  state_in = read_bad ? S_FINISH : S_READ_WAIT;
               end
               OP_SPLICE: begin
                  if (splice_bad || splice_big) begin
                     state_in = S_FINISH;
                  end else if (shift_needed) begin
                     state_in = S_SHIFT_RD;
                  end else if (ins_ff != '0) begin
                     state_in = S_ZERO;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               OP_SEARCH: begin
                  state_in = S_SRCH_RD;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_READ_WAIT: begin
            state_in = S_FINISH;
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = (ins_ff != '0) ? S_ZERO : S_FINISH;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_ZERO: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_FINISH;
            end
         end
         S_SRCH_RD: begin
            state_in = search_more ? S_SRCH_CMP : S_FINISH;
         end
         S_SRCH_CMP: begin
            state_in = S_SRCH_RD;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and RAM controls for each state.
   always_comb begin
      op_in        = op_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      ins_in       = ins_ff;
      eb_in        = eb_ff;
      pl_in        = pl_ff;
      key_in       = key_ff;
      used_in      = used_ff;
      fptr_in      = fptr_ff;
      frem_in      = frem_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      cnt_in       = cnt_ff;
      up_in        = up_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      wk_status_in = wk_status_ff;
      wk_found_in  = wk_found_ff;
      wk_eb_in     = wk_eb_ff;
      wk_pl_in     = wk_pl_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = dst_ff;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = src_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in        = op_type'(req_opcode);
               pos_in       = req_position;
               rem_in       = req_remove_count;
               ins_in       = req_insert_count;
               eb_in        = req_end_byte_in;
               pl_in        = req_payload_in[PAYLOAD_BITS-1:0];
               key_in       = req_byte_offset;
               wk_status_in = ST_OK;
               wk_found_in  = '0;
               wk_eb_in     = '0;
               wk_pl_in     = '0;
            end
         end
         S_DECODE: begin
            case (op_ff)
               OP_PUSH: begin
                  if (push_full) begin
                     wk_status_in = ST_CAPACITY;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = used_w[IDX_W-1:0];
                     mem_wr_data = {eb_ff, pl_ff};
                     used_in     = used_ff + CNT_W'(1);
                     fptr_in     = '0;
                     frem_in     = '0;
                  end
               end
               OP_READ: begin
                  if (read_bad) begin
                     wk_status_in = ST_BOUNDS;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = pos_w[IDX_W-1:0];
                  end
               end
               OP_SPLICE: begin
                  if (splice_bad) begin
                     wk_status_in = ST_BOUNDS;
                  end else if (splice_big) begin
                     wk_status_in = ST_CAPACITY;
                  end else begin
                     used_in = needed_w[CNT_W-1:0];
                     fptr_in = pos_w[CNT_W-1:0];
                     frem_in = ins_w[CNT_W-1:0];
                     up_in   = (ins_w > rem_w);
                     if (shift_needed) begin
                        // Growing moves the tail from its top end down,
                        // shrinking from its bottom end up.
                        cnt_in = tail_w[CNT_W-1:0];
                        if (ins_w > rem_w) begin
                           src_in = src_up_w[IDX_W-1:0];
                           dst_in = dst_up_w[IDX_W-1:0];
                        end else begin
                           src_in = span_w[IDX_W-1:0];
                           dst_in = dst_dn_w[IDX_W-1:0];
                        end
                     end else begin
                        cnt_in = ins_w[CNT_W-1:0];
                        dst_in = pos_w[IDX_W-1:0];
                     end
                  end
               end
               OP_FILL: begin
                  if (fill_none) begin
                     wk_status_in = ST_NO_GAP;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = fptr_w[IDX_W-1:0];
                     mem_wr_data = {eb_ff, pl_ff};
                     fptr_in     = fptr_ff + CNT_W'(1);
                     frem_in     = frem_ff - CNT_W'(1);
                  end
               end
               OP_SEARCH: begin
                  lo_in = '0;
                  hi_in = used_ff;
               end
               default: begin
                  wk_status_in = ST_OK;
               end
            endcase
         end
         S_READ_WAIT: begin
            wk_eb_in = mem_rd_data[ENTRY_W-1 -: END_W];
            wk_pl_in = mem_rd_data[PAYLOAD_BITS-1:0];
         end
         S_SHIFT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = src_ff;
         end
         S_SHIFT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = dst_ff;
            mem_wr_data = mem_rd_data;
            cnt_in      = cnt_ff - CNT_W'(1);
            if (up_ff) begin
               src_in = src_ff - IDX_W'(1);
               dst_in = dst_ff - IDX_W'(1);
            end else begin
               src_in = src_ff + IDX_W'(1);
               dst_in = dst_ff + IDX_W'(1);
            end
            // Last move: set up the gap clear.
            if (cnt_ff == CNT_W'(1)) begin
               dst_in = pos_w[IDX_W-1:0];
               cnt_in = ins_w[CNT_W-1:0];
            end
         end
         S_ZERO: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = dst_ff;
            mem_wr_data = '0;
            dst_in      = dst_ff + IDX_W'(1);
            cnt_in      = cnt_ff - CNT_W'(1);
         end
         S_SRCH_RD: begin
            if (search_more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid_w[IDX_W-1:0];
               mid_in      = mid_w[CNT_W-1:0];
            end else begin
               wk_found_in = lo_w[FIELD_W-1:0];
            end
         end
         S_SRCH_CMP: begin
            if (probe_le) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // The output word stays until the receiver takes it.
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         fptr_ff      <= '0;
         frem_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fptr_ff      <= fptr_in;
         frem_ff      <= frem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      rem_ff       <= rem_in;
      ins_ff       <= ins_in;
      eb_ff        <= eb_in;
      pl_ff        <= pl_in;
      key_ff       <= key_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      cnt_ff       <= cnt_in;
      up_ff        <= up_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      wk_status_ff <= wk_status_in;
      wk_found_ff  <= wk_found_in;
      wk_eb_ff     <= wk_eb_in;
      wk_pl_ff     <= wk_pl_in;
      if (load_out) begin
         rsp_status_ff <= wk_status_ff;
         rsp_found_ff  <= wk_found_ff;
         rsp_eb_ff     <= wk_eb_ff;
         rsp_pl_ff     <= wk_pl_ff;
         rsp_count_ff  <= used_w[FIELD_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_index  = rsp_found_ff;
   assign rsp_end_byte_out = rsp_eb_ff;
   assign rsp_payload_out  = DATA_W'(rsp_pl_ff);
   assign rsp_entry_count  = rsp_count_ff;

endmodule

`default_nettype wire

/* src/tspan_check.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "token_span_table_with_splice_defines.svh"

module tspan_check (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [tspan_pkg::ST_W-1:0]     rsp_status,
   input wire logic [tspan_pkg::FIELD_W-1:0]  rsp_found_index,
   input wire logic [tspan_pkg::END_W-1:0]    rsp_end_byte_out,
   input wire logic [tspan_pkg::DATA_W-1:0]   rsp_payload_out,
   input wire logic [tspan_pkg::FIELD_W-1:0]  rsp_entry_count
);

   import tspan_pkg::*;

   // A stalled result word holds.
   `TSPAN_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_found_index) && $stable(rsp_end_byte_out) && $stable(rsp_payload_out) && $stable(rsp_entry_count), "stalled result word changed")

   // The sequencer is busy in the cycle after it takes a word.
   `TSPAN_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall, "block took a second word back to back")

   // Only a successful read returns table data.
   `TSPAN_ASSERT_NOW(a_no_data_on_error, rsp_valid && rsp_status != ST_OK, rsp_end_byte_out == '0 && rsp_payload_out == '0, "rejected word returned table data")

   // A search never points past the end of the table.
   `TSPAN_ASSERT_NOW(a_found_in_range, rsp_valid, rsp_found_index <= rsp_entry_count, "search index beyond entry count")

endmodule

bind token_span_table_with_splice tspan_check u_tspan_check (.*);

`default_nettype wire

/* tb/sv/token_span_table_with_splice_tb.sv */
`timescale 1ns / 1ps

module token_span_table_with_splice_tb;
   import tspan_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int WORD_TARGET    = 1250;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 300;

   // Opcodes the block leaves unused; they must answer ok and change nothing.
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

   localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};
   localparam logic [END_W-1:0]   END_MAX   = {END_W{1'b1}};
   localparam logic [DATA_W-1:0]  DATA_MAX  = {DATA_W{1'b1}};

   // One request word as presented on the req_ ports.
   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] remove_count;
      logic [FIELD_W-1:0] insert_count;
      logic [END_W-1:0]   end_offset;
      logic [DATA_W-1:0]  payload;
      logic [END_W-1:0]   search_key;
   } table_word_type;

   // One result word as seen on the rsp_ ports.
   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] found_index;
      logic [END_W-1:0]   end_offset;
      logic [DATA_W-1:0]  payload;
      logic [FIELD_W-1:0] entry_count;
   } table_answer_type;

   // Tracks the token table as the block should hold it and queues the
   // answers it should give, oldest first.
   class span_table_model;
      logic [END_W-1:0]        ends     [CAPACITY];
      logic [PAYLOAD_BITS-1:0] payloads [CAPACITY];
      int                      live_count;
      int                      gap_next;
      int                      gap_left;
      table_answer_type        predicted_answers[$];
      int                      answers_seen;
      int                      fails;

      function new();
         foreach (ends[i]) begin
            ends[i]     = '0;
            payloads[i] = '0;
         end
         live_count   = 0;
         gap_next     = 0;
         gap_left     = 0;
         answers_seen = 0;
         fails        = 0;
      endfunction

      // Applies one accepted word to the table and returns its answer.
      function table_answer_type apply_word(table_word_type w);
         table_answer_type        a;
         int                      pos;
         int                      rem;
         int                      ins;
         int                      needed;
         int                      tail;
         int                      lo;
         int                      hi;
         int                      mid;
         logic [END_W-1:0]        old_ends [CAPACITY];
         logic [PAYLOAD_BITS-1:0] old_pays [CAPACITY];
         a        = '0;
         a.status = ST_OK;
         pos      = w.position;
         rem      = w.remove_count;
         ins      = w.insert_count;
         case (w.opcode)
            OP_PUSH: begin
               // A full table rejects the push and keeps any open gap.
               if (live_count >= CAPACITY) begin
                  a.status = ST_CAPACITY;
               end else begin
                  ends[live_count]     = w.end_offset;
                  payloads[live_count] = PAYLOAD_BITS'(w.payload);
                  live_count++;
                  gap_next = 0;
                  gap_left = 0;
               end
            end
            OP_READ: begin
               if (pos >= live_count) begin
                  a.status = ST_BOUNDS;
               end else begin
                  a.end_offset = ends[pos];
                  a.payload    = DATA_W'(payloads[pos]);
               end
            end
            OP_SPLICE: begin
               if (pos > live_count || pos + rem > live_count) begin
                  a.status = ST_BOUNDS;
               end else begin
                  needed = live_count - rem + ins;
                  if (needed > CAPACITY) begin
                     a.status = ST_CAPACITY;
                  end else begin
                     // Move the tail behind the removed run, then clear the gap.
                     tail     = live_count - pos - rem;
                     old_ends = ends;
                     old_pays = payloads;
                     for (int i = 0; i < tail; i++) begin
                        ends[pos + ins + i]     = old_ends[pos + rem + i];
                        payloads[pos + ins + i] = old_pays[pos + rem + i];
                     end
                     for (int i = 0; i < ins; i++) begin
                        ends[pos + i]     = '0;
                        payloads[pos + i] = '0;
                     end
                     live_count = needed;
                     gap_next   = pos;
                     gap_left   = ins;
                  end
               end
            end
            OP_FILL: begin
               if (gap_left == 0 || gap_next >= CAPACITY) begin
                  a.status = ST_NO_GAP;
               end else begin
                  ends[gap_next]     = w.end_offset;
                  payloads[gap_next] = PAYLOAD_BITS'(w.payload);
                  gap_next++;
                  gap_left--;
               end
            end
            OP_SEARCH: begin
               // Binary probe sequence; on an unordered table the result
               // follows the probes, not a linear scan.
               lo = 0;
               hi = live_count;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (ends[mid] <= w.search_key) lo = mid + 1;
                  else hi = mid;
               end
               a.found_index = FIELD_W'(lo);
            end
            default: begin
            end
         endcase
         a.entry_count = FIELD_W'(live_count);
         return a;
      endfunction

      function void take_word(table_word_type w);
         predicted_answers.push_back(apply_word(w));
      endfunction

      task report(string what);
         $display("mismatch at result %0d: %s", answers_seen, what);
         fails++;
      endtask

      task check_answer(logic [ST_W-1:0] status, logic [FIELD_W-1:0] found_index,
                        logic [END_W-1:0] end_offset, logic [DATA_W-1:0] payload,
                        logic [FIELD_W-1:0] entry_count);
         table_answer_type want;
         if (predicted_answers.size() == 0) begin
            report($sformatf("result word with none awaited, status %0d", status));
         end else begin
            want = predicted_answers.pop_front();
            if (status !== want.status)
               report($sformatf("status %0d, wanted %0d", status, want.status));
            if (found_index !== want.found_index)
               report($sformatf("found_index %0d, wanted %0d", found_index,
                                want.found_index));
            if (end_offset !== want.end_offset)
               report($sformatf("end_byte_out %h, wanted %h", end_offset,
                                want.end_offset));
            if (payload !== want.payload)
               report($sformatf("payload_out %h, wanted %h", payload, want.payload));
            if (entry_count !== want.entry_count)
               report($sformatf("entry_count %0d, wanted %0d", entry_count,
                                want.entry_count));
         end
         answers_seen++;
      endtask
   endclass

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_opcode       = '0;
   logic [FIELD_W-1:0]  req_position     = '0;
   logic [FIELD_W-1:0]  req_remove_count = '0;
   logic [FIELD_W-1:0]  req_insert_count = '0;
   logic [END_W-1:0]    req_end_byte_in  = '0;
   logic [DATA_W-1:0]   req_payload_in   = '0;
   logic [END_W-1:0]    req_byte_offset  = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [ST_W-1:0]     rsp_status;
   logic [FIELD_W-1:0]  rsp_found_index;
   logic [END_W-1:0]    rsp_end_byte_out;
   logic [DATA_W-1:0]   rsp_payload_out;
   logic [FIELD_W-1:0]  rsp_entry_count;

   span_table_model span_model = new();
   int              words_sent   = 0;
   int              send_calm    = 0;
   int              stall_left   = 0;
   int              stall_calm   = 0;
   int              quiet_cycles = 0;

   token_span_table_with_splice i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_position     (req_position),
      .req_remove_count (req_remove_count),
      .req_insert_count (req_insert_count),
      .req_end_byte_in  (req_end_byte_in),
      .req_payload_in   (req_payload_in),
      .req_byte_offset  (req_byte_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found_index  (rsp_found_index),
      .rsp_end_byte_out (rsp_end_byte_out),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_entry_count  (rsp_entry_count)
   );

   always #CLOCK_HALF clock = ~clock;

   // Idle stretch length: mostly short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Result side stalls at random, with calm stretches in between.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_calm > 0) begin
         stall_calm <= stall_calm - 1;
         rsp_stall  <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
         stall_calm <= $urandom_range(50, 300);
         rsp_stall  <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
         stall_left <= idle_length() - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every result word taken is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         span_model.check_answer(rsp_status, rsp_found_index, rsp_end_byte_out,
                                 rsp_payload_out, rsp_entry_count);
   end

   // Count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall == 1'b0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   function automatic table_word_type make_word(logic [OP_W-1:0] op,
                                                logic [FIELD_W-1:0] pos,
                                                logic [FIELD_W-1:0] rem,
                                                logic [FIELD_W-1:0] ins,
                                                logic [END_W-1:0] eb,
                                                logic [DATA_W-1:0] pl,
                                                logic [END_W-1:0] key);
      table_word_type w;
      w.opcode       = op;
      w.position     = pos;
      w.remove_count = rem;
      w.insert_count = ins;
      w.end_offset   = eb;
      w.payload      = pl;
      w.search_key   = key;
      return w;
   endfunction

   function automatic table_word_type random_word();
      return make_word(OP_W'($urandom_range(0, 7)), FIELD_W'($urandom), FIELD_W'($urandom),
                       FIELD_W'($urandom), $urandom, $urandom, $urandom);
   endfunction

   // Presents one word, sometimes after a random gap, and holds it until it is taken.
   task automatic send_word(table_word_type w);
      int gap;
      if (send_calm > 0) begin
         send_calm--;
      end else if ($urandom_range(0, 1) == 0) begin
         gap = idle_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= w.opcode;
      req_position     <= w.position;
      req_remove_count <= w.remove_count;
      req_insert_count <= w.insert_count;
      req_end_byte_in  <= w.end_offset;
      req_payload_in   <= w.payload;
      req_byte_offset  <= w.search_key;
      do @(posedge clock); while (req_stall !== 1'b0);
      span_model.take_word(w);
      words_sent++;
   endtask

   // Sender holds off until every awaited result word has come back.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (span_model.predicted_answers.size() != 0) @(posedge clock);
   endtask

   // Push that mostly keeps the end offsets ascending.
   task automatic send_push();
      table_word_type w;
      int             live;
      live     = span_model.live_count;
      w        = random_word();
      w.opcode = OP_PUSH;
      if (live > 0 && $urandom_range(0, 9) != 0)
         w.end_offset = span_model.ends[live - 1] + END_W'($urandom_range(1, 5000));
      send_word(w);
   endtask

   task automatic send_read();
      table_word_type w;
      int             live;
      live     = span_model.live_count;
      w        = random_word();
      w.opcode = OP_READ;
      if (live > 0 && $urandom_range(0, 9) != 0)
         w.position = FIELD_W'($urandom_range(0, live - 1));
      send_word(w);
   endtask

   // Search keys land on, just below or just above a stored end offset.
   task automatic send_search();
      table_word_type w;
      int             live;
      int             pick;
      live     = span_model.live_count;
      w        = random_word();
      w.opcode = OP_SEARCH;
      if (live > 0 && $urandom_range(0, 4) != 0) begin
         pick         = $urandom_range(0, live - 1);
         w.search_key = span_model.ends[pick] + END_W'($urandom_range(0, 2)) - 32'd1;
      end
      send_word(w);
   endtask

   // Fill word whose end offset sits between the gap's neighbors.
   task automatic send_fill();
      table_word_type w;
      int             nxt;
      int             lft;
      int             live;
      longint         lower;
      longint         upper;
      longint         step;
      nxt      = span_model.gap_next;
      lft      = span_model.gap_left;
      live     = span_model.live_count;
      w        = random_word();
      w.opcode = OP_FILL;
      if (lft > 0) begin
         lower = (nxt > 0) ? span_model.ends[nxt - 1] : 0;
         upper = (nxt + lft < live) ? span_model.ends[nxt + lft] : lower + 20000;
         step  = (upper > lower) ? (upper - lower) / (lft + 1) : 0;
         w.end_offset = END_W'(lower + ((step > 0) ? $urandom_range(1, 32'(step)) : 0));
      end
      send_word(w);
   endtask

   // Well-formed splice followed by its fill words, sometimes interrupted.
   task automatic send_splice_run();
      table_word_type w;
      int             live;
      int             left;
      int             room;
      int             k;
      live     = span_model.live_count;
      w        = random_word();
      w.opcode = OP_SPLICE;
      w.position = FIELD_W'($urandom_range(0, live));
      left = live - w.position;
      w.remove_count = FIELD_W'(($urandom_range(0, 9) < 7) ?
                                $urandom_range(0, (left < 3) ? left : 3) :
                                $urandom_range(0, left));
      room = CAPACITY - (live - w.remove_count);
      w.insert_count = FIELD_W'(($urandom_range(0, 19) != 0) ?
                                $urandom_range(0, (room < 5) ? room : 5) :
                                $urandom_range(0, room));
      send_word(w);
      for (k = 0; k < w.insert_count; k++) begin
         // Reads and searches leave the gap open; a stray word may close it.
         if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) == 0) send_read();
            else send_search();
         end
         if ($urandom_range(0, 39) == 0) begin
            send_word(random_word());
            break;
         end
         send_fill();
      end
      if ($urandom_range(0, 9) == 0) send_fill();
   endtask

   // Drops a tail of the table so it does not stay full.
   task automatic send_trim();
      int live;
      int pos;
      live = span_model.live_count;
      pos  = $urandom_range(0, live);
      send_word(make_word(OP_SPLICE, FIELD_W'(pos), FIELD_W'(live - pos), '0,
                          $urandom, $urandom, $urandom));
   endtask

   initial begin
      int r;
      int burst;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed words: empty table, extremes, gap handling, full table.
      send_word(make_word(OP_FILL, 0, 0, 0, 32'h1234_5678, 32'h8765_4321, 0));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_SEARCH, 0, 0, 0, 0, 0, END_MAX));
      send_word(make_word(OP_SPLICE, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_SPLICE, 1, 0, 0, 0, 0, 0));
      send_word(make_word(OP_PUSH, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_PUSH, 0, 0, 0, END_MAX, DATA_MAX, 0));
      send_word(make_word(OP_READ, 1, 0, 0, 0, 0, 0));
      send_word(make_word(OP_READ, FIELD_MAX, 0, 0, 0, 0, 0));
      send_word(make_word(OP_SEARCH, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_SPARE_A, FIELD_MAX, FIELD_MAX, FIELD_MAX, END_MAX, DATA_MAX,
                          END_MAX));
      send_word(make_word(OP_SPARE_C, FIELD_MAX, FIELD_MAX, FIELD_MAX, END_MAX, DATA_MAX,
                          END_MAX));
      send_word(make_word(OP_SPLICE, 1, 0, 2, 0, 0, 0));
      send_word(make_word(OP_FILL, 0, 0, 0, 32'd5, 32'hA5A5_A5A5, 0));
      send_word(make_word(OP_READ, 2, 0, 0, 0, 0, 0));
      send_word(make_word(OP_FILL, 0, 0, 0, 32'd6, 32'h5A5A_5A5A, 0));
      send_word(make_word(OP_FILL, 0, 0, 0, 32'd9, 32'd9, 0));
      send_word(make_word(OP_SPLICE, 0, FIELD_MAX, 0, 0, 0, 0));
      send_word(make_word(OP_SPLICE, 4, 0, FIELD_MAX, 0, 0, 0));
      send_word(make_word(OP_SPLICE, 4, 0, 7'd60, 0, 0, 0));
      send_word(make_word(OP_PUSH, 0, 0, 0, 32'd1, 32'd1, 0));
      send_word(make_word(OP_FILL, 0, 0, 0, 32'd7, 32'h0F0F_0F0F, 0));
      send_word(make_word(OP_SEARCH, 0, 0, 0, 0, 0, 32'h8000_0000));
      send_word(make_word(OP_READ, 7'd63, 0, 0, 0, 0, 0));
      send_word(make_word(OP_SPLICE, 0, 7'd64, 0, 0, 0, 0));
      wait_for_quiet();

      // Random part: mostly well-formed runs, with some noise.
      while (words_sent < WORD_TARGET) begin
         r = $urandom_range(0, 99);
         if (span_model.live_count > 40 && r < 15) begin
            send_trim();
         end else if (r < 35) begin
            send_splice_run();
         end else if (r < 55) begin
            burst = $urandom_range(1, 4);
            repeat (burst) send_push();
         end else if (r < 70) begin
            send_read();
         end else if (r < 85) begin
            send_search();
         end else if (r < 95) begin
            send_word(random_word());
         end else begin
            send_trim();
         end
         if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
         if ($urandom_range(0, 149) == 0) wait_for_quiet();
      end

      // Let the last results arrive, then allow for anything stray.
      req_valid <= 1'b0;
      @(posedge clock);
      while (span_model.predicted_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (span_model.fails == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* token_span_table_with_splice.f */
+incdir+src
src/tspan_pkg.sv
src/tspan_ram.sv
src/token_span_table_with_splice.sv
src/tspan_check.sv
tb/sv/token_span_table_with_splice_tb.sv
